// ===== sv/sspr_pkg.sv =====
`default_nettype none

package sspr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_ERROR   = 3'd3,
    PH_FACTORS = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_SERVO    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_FACTOR = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic {
    REG_TIMEOUT_TICKS = 1'b0,
    REG_FAC_LIMIT     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] factor_index;
    logic [7:0] factor_value;
    status_t    status;
    logic [7:0] dev_id;
    logic [7:0] servo_error;
    logic [7:0] fac_total;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/sspr_parse.sv =====
`default_nettype none

module sspr_parse
  import sspr_pkg::*;
#(
  parameter int HEADER_COUNT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire cmd_t        cmd,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] timeout_ticks,
  input  wire logic [7:0]  fac_limit,
  output logic             res_valid,
  output result_t          res
);

  localparam logic [1:0] HDR_LAST = 2'(HEADER_COUNT);

  logic        armed_r, armed_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  headers_r, headers_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  pos_r, pos_nxt;

  logic [7:0]  sum_add;
  logic [1:0]  headers_inc;
  logic [15:0] idle_sat;
  logic        pos_below_max;
  logic        timed_out;

  assign sum_add       = sum_r + rx_byte;
  assign headers_inc   = headers_r + 2'd1;
  assign idle_sat      = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
  assign pos_below_max = pos_r < fac_limit;
  assign timed_out     = idle_sat >= timeout_ticks;

  // next state
  always_comb begin
    armed_nxt   = armed_r;
    phase_nxt   = phase_r;
    headers_nxt = headers_r;
    idle_nxt    = idle_r;
    sum_nxt     = sum_r;
    id_nxt      = id_r;
    err_nxt     = err_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    if (step) begin
      unique case (cmd)
        CMD_START: begin
          armed_nxt   = 1'b1;
          phase_nxt   = PH_HEADER;
          headers_nxt = '0;
          idle_nxt    = '0;
          sum_nxt     = '0;
          id_nxt      = '0;
          err_nxt     = '0;
          left_nxt    = '0;
          pos_nxt     = '0;
        end
        CMD_BYTE: begin
          if (armed_r) begin
            idle_nxt = '0;
            unique case (phase_r)
              PH_HEADER: begin
                if (rx_byte != SYNC_BYTE) begin
                  armed_nxt = 1'b0;
                end else begin
                  headers_nxt = headers_inc;
                  if (headers_inc >= HDR_LAST) phase_nxt = PH_ID;
                end
              end
              PH_ID: begin
                id_nxt    = rx_byte;
                sum_nxt   = rx_byte;
                phase_nxt = PH_SIZE;
              end
              PH_SIZE: begin
                sum_nxt   = sum_add;
                left_nxt  = (rx_byte > 8'd2) ? rx_byte - 8'd2 : 8'd0;
                phase_nxt = PH_ERROR;
              end
              PH_ERROR: begin
                err_nxt   = rx_byte;
                sum_nxt   = sum_add;
                pos_nxt   = '0;
                phase_nxt = (left_r != 8'd0) ? PH_FACTORS : PH_CHECK;
              end
              PH_FACTORS: begin
                sum_nxt  = sum_add;
                pos_nxt  = pos_r + 8'd1;
                left_nxt = left_r - 8'd1;
                if (left_r == 8'd1) phase_nxt = PH_CHECK;
              end
              PH_CHECK: begin
                armed_nxt = 1'b0;
              end
              default: begin
                armed_nxt = 1'b0;
              end
            endcase
          end
        end
        CMD_TICK: begin
          if (armed_r) begin
            idle_nxt = idle_sat;
            if (timed_out) armed_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the step
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step && armed_r) begin
      unique case (cmd)
        CMD_BYTE: begin
          unique case (phase_r)
            PH_HEADER: begin
              if (rx_byte != SYNC_BYTE) begin
                res_valid    = 1'b1;
                res.kind     = KIND_STATUS;
                res.status   = ST_TIMEOUT;
                res.dev_id   = id_r;
                res.servo_error = err_r;
              end
            end
            PH_FACTORS: begin
              if (pos_below_max) begin
                res_valid        = 1'b1;
                res.kind         = KIND_FACTOR;
                res.factor_index = pos_r;
                res.factor_value = rx_byte;
              end
            end
            PH_CHECK: begin
              res_valid       = 1'b1;
              res.kind        = KIND_STATUS;
              res.dev_id      = id_r;
              res.servo_error = err_r;
              if (rx_byte != ~sum_r) begin
                res.status = ST_CHECKSUM;
              end else begin
                res.status    = (err_r != 8'd0) ? ST_SERVO : ST_OK;
                res.fac_total = pos_below_max ? pos_r : fac_limit;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          if (timed_out) begin
            res_valid       = 1'b1;
            res.kind        = KIND_STATUS;
            res.status      = ST_TIMEOUT;
            res.dev_id      = id_r;
            res.servo_error = err_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      phase_r   <= PH_HEADER;
      headers_r <= '0;
      idle_r    <= '0;
      sum_r     <= '0;
      id_r      <= '0;
      err_r     <= '0;
      left_r    <= '0;
      pos_r     <= '0;
    end else begin
      armed_r   <= armed_nxt;
      phase_r   <= phase_nxt;
      headers_r <= headers_nxt;
      idle_r    <= idle_nxt;
      sum_r     <= sum_nxt;
      id_r      <= id_nxt;
      err_r     <= err_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/servo_status_packet_receiver.sv =====
// channel  | handshake                | payload
// in_      | in_tvalid / in_tready    | tuser: command, tdata: rx_byte
// out_     | out_tvalid / out_tready  | tuser: kind, tdata: factor and status fields
// cfg_     | cfg_we (no wait)         | cfg_addr, cfg_wdata
//
// one request per clock unless out_tready stalls; a request is registered, stepped
// through the packet parser once the output register can take its result, and its
// result (if any) lands in the output register, which drives out_tvalid.
// rst_n is synchronous; it disarms the parser and empties both stages.
// a stall on out_tready holds the parser stage, and in_tready drops only when it is held.
`default_nettype none

module servo_status_packet_receiver
  import sspr_pkg::*;
#(
  parameter int HEADER_COUNT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] command

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] factor_index, [15:8] factor_value, [17:16] status, [25:18] dev_id,
  // [33:26] servo_error, [41:34] fac_total, [47:42] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic             out_tuser,  // [0] kind

  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] timeout_r;
  logic [7:0]  fac_limit_r;

  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic        s1_go;

  logic        res_valid;
  result_t     res;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= 16'd10;
      fac_limit_r <= 8'd4;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_TIMEOUT_TICKS: timeout_r   <= cfg_wdata;
        REG_FAC_LIMIT:     fac_limit_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= cmd_t'(in_tuser);
      s1_byte_r <= in_tdata;
    end
  end

  sspr_parse #(
    .HEADER_COUNT(HEADER_COUNT)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .cmd          (s1_cmd_r),
    .rx_byte      (s1_byte_r),
    .timeout_ticks(timeout_r),
    .fac_limit    (fac_limit_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {6'd0, out_r.fac_total, out_r.servo_error, out_r.dev_id,
                       out_r.status, out_r.factor_value, out_r.factor_index};

`ifndef ASSERT_OFF
  a_new_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> $past(s1_valid_r))
    else $error("result appeared without a request in the parser stage");

  a_factor_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.kind == KIND_FACTOR |->
      out_r.status == ST_OK && out_r.dev_id == 8'd0 &&
      out_r.servo_error == 8'd0 && out_r.fac_total == 8'd0)
    else $error("factor result carries status fields");

  a_failed_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.kind == KIND_STATUS &&
      (out_r.status == ST_TIMEOUT || out_r.status == ST_CHECKSUM) |->
      out_r.fac_total == 8'd0 && out_r.factor_index == 8'd0)
    else $error("failed packet reports a factor count");

  a_ready_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while the parser stage can move");
`endif

endmodule

`default_nettype wire
